### rtl/vsdf_pkg.sv
// shared types, constants and helpers for the vertical speed and depth fusion block
package vsdf_pkg;

    localparam int FracBits    = 16;
    localparam int SineEntries = 256;
    localparam int SineBits    = 30;
    localparam int PhaseBits   = $clog2(4 * SineEntries);
    localparam int QuadBits    = $clog2(SineEntries);

    localparam logic signed [31:0] GravityQ    = 32'sd642253;
    localparam logic [16:0]        WeightOne   = 17'd65536;

    localparam logic [16:0]        FuseReset   = 17'd64225;
    localparam logic [16:0]        SmoothReset = 17'd6554;
    localparam logic [24:0]        StepTReset  = 25'd16777;
    localparam logic [16:0]        StepRReset  = 17'd1000;
    localparam logic [31:0]        LevFReset   = 32'd8782;
    localparam logic [31:0]        LevSReset   = 32'hFFFF_E51F;

    typedef enum logic [2:0] {
        REG_FUSE      = 3'd0,
        REG_SMOOTH    = 3'd1,
        REG_STEP_TIME = 3'd2,
        REG_STEP_RATE = 3'd3,
        REG_ROLL_TRIM = 3'd4,
        REG_PITCH_TRIM = 3'd5,
        REG_LEVER_FWD = 3'd6,
        REG_LEVER_SIDE = 3'd7
    } reg_idx_t;

    // quarter-wave sine table, Q1.30, built at elaboration by a Taylor series
    typedef logic [30:0] sine_tab_t [SineEntries + 1];

    // next Taylor term divided by (2k)(2k+1)
    function automatic longint unsigned taylor_div(input longint unsigned v, input int k);
        case (k)
            1:  return v / 64'd6;
            2:  return v / 64'd20;
            3:  return v / 64'd42;
            4:  return v / 64'd72;
            5:  return v / 64'd110;
            6:  return v / 64'd156;
            7:  return v / 64'd210;
            8:  return v / 64'd272;
            9:  return v / 64'd342;
            10: return v / 64'd420;
            11: return v / 64'd506;
            12: return v / 64'd600;
            default: return v;
        endcase
    endfunction

    function automatic sine_tab_t build_sines();
        sine_tab_t tab;
        longint unsigned x, x2, t;
        longint s;
        for (int i = 0; i <= SineEntries; i++) begin
            x  = (longint'(i) * 64'd1686629713) / SineEntries;
            x2 = (x * x) >> SineBits;
            t  = x;
            s  = longint'(x);
            for (int k = 1; k <= 12; k++) begin
                t = taylor_div((t * x2) >> SineBits, k);
                if (k[0]) s = s - longint'(t);
                else s = s + longint'(t);
            end
            if (s < 0) s = 0;
            if (s > (64'sd1 <<< SineBits)) s = 64'sd1 <<< SineBits;
            tab[i] = 31'(s);
        end
        return tab;
    endfunction

    localparam sine_tab_t SineTab = build_sines();

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

endpackage

### rtl/vsdf_mac.sv
// digit-serial signed multiply-add with a bias before and an addend after a rounding shift
module vsdf_mac (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] mcand,
    input  logic signed [63:0] mplier,
    input  logic signed [63:0] bias,
    input  logic signed [63:0] addend,
    input  logic [5:0]         shift,
    output logic               done,
    output logic signed [63:0] result
);
    // two-bit digits of the multiplicand magnitude per cycle
    logic [63:0]        mag_reg, mag_next;
    logic [127:0]       acc_reg, acc_next;
    logic [127:0]       mc_reg, mc_next;
    logic               neg_reg, neg_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [63:0] res_reg, res_next;
    logic signed [63:0] bias_reg, bias_next;
    logic signed [63:0] addend_reg, addend_next;
    logic [5:0]         sh_reg, sh_next;
    logic [127:0]       prod;
    logic signed [127:0] sprod, half, rnd, tot;

    always_comb begin
        mag_next = mag_reg; acc_next = acc_reg; mc_next = mc_reg;
        neg_next = neg_reg; cnt_next = cnt_reg; busy_next = busy_reg;
        done_next = 1'b0; res_next = res_reg;
        bias_next = bias_reg; addend_next = addend_reg; sh_next = sh_reg;
        prod = acc_reg;
        // bias joins the product before rounding, addend after it
        sprod = (neg_reg ? -$signed(prod) : $signed(prod)) + 128'(bias_reg);
        half = (sh_reg == 6'd0) ? 128'sd0 : (128'sd1 <<< (sh_reg - 6'd1));
        rnd = (sprod >= 0) ? ((sprod + half) >>> sh_reg)
                           : -((-sprod + half) >>> sh_reg);
        tot = rnd + 128'(addend_reg);
        if (start) begin
            mag_next = mcand[63] ? 64'(-mcand) : 64'(mcand);
            mc_next = mplier[63] ? 128'(-mplier) : 128'(mplier);
            neg_next = mcand[63] ^ mplier[63];
            acc_next = '0; cnt_next = '0; busy_next = 1'b1;
            bias_next = bias; addend_next = addend; sh_next = shift;
        end else if (busy_reg) begin
            acc_next = acc_reg + (mag_reg[1:0] == 2'd0 ? 128'd0 :
                       mag_reg[1:0] == 2'd1 ? mc_reg :
                       mag_reg[1:0] == 2'd2 ? (mc_reg << 1) : (mc_reg + (mc_reg << 1)));
            mc_next = mc_reg << 2;
            mag_next = mag_reg >> 2;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
            end
        end else if (cnt_reg == 6'd32) begin
            res_next = 64'(tot);
            done_next = 1'b1;
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        mag_reg <= mag_next; acc_reg <= acc_next; mc_reg <= mc_next;
        neg_reg <= neg_next; res_reg <= res_next;
        bias_reg <= bias_next; addend_reg <= addend_next; sh_reg <= sh_next;
    end

    assign done = done_reg;
    assign result = res_reg;
endmodule

### rtl/vertical_speed_depth_fusion_top.sv
// top level of the vertical speed and depth fusion block
// One sample item in, one result item out. Each item runs through a single shared
// multiply-add unit that retires two multiplicand bits per cycle; seven products run
// in sequence, each with a start, 32 digit steps, rounding and handoff, and a new
// item is taken only once the last one has been handed to the result register.
// The result register holds the item until taken, while
// the next item may already be accepted; a result still waiting when the next one
// is ready stalls it in its output stage. Weights above one act as one. Arm captures
// depth and yaw baselines from the same sample so both outputs read zero unless the depth baseline saturates.
module vertical_speed_depth_fusion_top import vsdf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_vertical[31:0], depth_raw[63:32], roll_angle[88:64],
    // pitch_angle[113:89], yaw_angle[138:114], pad
    input  logic [143:0] s_tdata,
    // arm
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vertical_speed[31:0], depth_out[63:32], roll_out[95:64],
    // pitch_out[127:96], yaw_out[159:128]
    output logic [159:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_SA, ST_SD, ST_VA, ST_VD, ST_FUSE, ST_PSIN, ST_RSIN, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [16:0] fuse_reg, smooth_reg, rate_reg;
    logic [24:0] stept_reg;
    logic signed [24:0] rtrim_reg, ptrim_reg;
    logic signed [31:0] levf_reg, levs_reg;

    // filter state
    logic signed [31:0] sacc_reg, sacc_next, sdep_reg, sdep_next;
    logic signed [31:0] spd_reg, spd_next, dbase_reg, dbase_next;
    logic signed [31:0] ybase_reg, ybase_next;

    // captured item
    logic signed [31:0] acc_in_reg, dep_in_reg;
    logic signed [24:0] roll_reg, pitch_reg, yaw_reg;
    logic               arm_reg;

    // intermediates
    logic signed [63:0] tmp_reg, tmp_next, va_reg, va_next, corr_reg, corr_next;
    logic signed [31:0] old_dep_reg, old_dep_next;

    // result register
    logic         out_valid_reg, out_valid_next;
    logic [159:0] out_reg, out_next;

    // shared unit
    logic               mac_start, mac_done;
    logic signed [63:0] mac_a, mac_b, mac_bias, mac_c, mac_res;
    logic [5:0]         mac_sh;
    logic               issued_reg, issued_next;

    logic [16:0] alpha, beta;
    logic signed [63:0] sin_p, sin_r;
    logic signed [63:0] dc, dbase_use, ybase_use;

    assign alpha = (fuse_reg > WeightOne) ? WeightOne : fuse_reg;
    assign beta  = (smooth_reg > WeightOne) ? WeightOne : smooth_reg;

    function automatic logic signed [63:0] sine_deg(input logic signed [24:0] ang);
        logic        neg;
        logic [63:0] m, n;
        logic [15:0] y;
        logic [31:0] yp;
        logic [PhaseBits-1:0] pw;
        logic [1:0]  q;
        logic [QuadBits-1:0] r;
        logic signed [63:0] s;
        neg = ang[24];
        m = neg ? 64'(-64'(ang)) : 64'(ang);
        // phase = round(m * 1024 / (360 << 16)) = floor((m + 11520) / 23040)
        n = m + 64'd11520;
        // 23040 = 512 * 45: shift, then divide by 45 through a reciprocal multiply
        y = n[24:9];
        yp = 32'(y) * 32'd23302;
        pw = yp[PhaseBits+19:20];
        q = pw[PhaseBits-1 -: 2];
        r = pw[QuadBits-1:0];
        s = q[0] ? 64'(SineTab[SineEntries - int'(r)]) : 64'(SineTab[r]);
        if (q[1]) s = -s;
        return neg ? -s : s;
    endfunction

    assign sin_p = sine_deg(pitch_reg);
    assign sin_r = sine_deg(roll_reg);

    vsdf_mac u_mac (
        .aclk(aclk), .aresetn(aresetn), .start(mac_start),
        .mcand(mac_a), .mplier(mac_b), .bias(mac_bias), .addend(mac_c), .shift(mac_sh),
        .done(mac_done), .result(mac_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    always_comb begin
        state_next = state_reg; issued_next = issued_reg;
        sacc_next = sacc_reg; sdep_next = sdep_reg; spd_next = spd_reg;
        dbase_next = dbase_reg; ybase_next = ybase_reg;
        tmp_next = tmp_reg; va_next = va_reg; corr_next = corr_reg;
        old_dep_next = old_dep_reg;
        out_valid_next = out_valid_reg; out_next = out_reg;
        mac_start = 1'b0; mac_a = '0; mac_b = '0; mac_bias = '0; mac_c = '0; mac_sh = '0;
        dc = 64'(dep_in_reg) + corr_reg;
        dbase_use = arm_reg ? sat32(-dc) : 64'(dbase_reg);
        ybase_use = arm_reg ? sat32(-64'(yaw_reg)) : 64'(ybase_reg);
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;

        // each compute state issues one product, then waits for it
        case (state_reg)
            ST_IDLE: begin
                issued_next = 1'b0;
                if (s_tvalid) state_next = ST_SA;
            end
            ST_SA: begin
                // smoothed accel plus gravity: beta*(a+g-prev) + prev*65536, rounded
                mac_a = 64'(beta);
                mac_b = 64'(acc_in_reg) + 64'(GravityQ) - 64'(sacc_reg);
                mac_bias = 64'(sacc_reg) <<< 16; mac_sh = 6'd16;
                if (mac_done) begin
                    sacc_next = 32'(sat32(mac_res)); state_next = ST_SD; issued_next = 1'b0;
                end
            end
            ST_SD: begin
                mac_a = 64'(beta);
                mac_b = 64'(dep_in_reg) - 64'(sdep_reg);
                mac_bias = 64'(sdep_reg) <<< 16; mac_sh = 6'd16;
                if (mac_done) begin
                    old_dep_next = sdep_reg;
                    sdep_next = 32'(sat32(mac_res)); state_next = ST_VA; issued_next = 1'b0;
                end
            end
            ST_VA: begin
                mac_a = 64'(sacc_reg); mac_b = 64'(stept_reg);
                mac_c = 64'(spd_reg); mac_sh = 6'd24;
                if (mac_done) begin
                    va_next = sat32(mac_res); state_next = ST_VD; issued_next = 1'b0;
                end
            end
            ST_VD: begin
                mac_a = 64'(sdep_reg) - 64'(old_dep_reg); mac_b = 64'(rate_reg);
                mac_c = '0; mac_sh = 6'd0;
                if (mac_done) begin
                    tmp_next = sat32(mac_res); state_next = ST_FUSE; issued_next = 1'b0;
                end
            end
            ST_FUSE: begin
                // alpha*va + (1-alpha)*vd = alpha*(va-vd) + vd*65536
                mac_a = 64'(alpha); mac_b = va_reg - tmp_reg;
                mac_bias = tmp_reg <<< 16; mac_sh = 6'd16;
                if (mac_done) begin
                    spd_next = 32'(sat32(mac_res)); state_next = ST_PSIN; issued_next = 1'b0;
                end
            end
            ST_PSIN: begin
                mac_a = sin_p; mac_b = 64'(levf_reg); mac_c = '0; mac_sh = 6'd30;
                if (mac_done) begin
                    corr_next = mac_res; state_next = ST_RSIN; issued_next = 1'b0;
                end
            end
            ST_RSIN: begin
                mac_a = -sin_r; mac_b = 64'(levs_reg); mac_c = '0; mac_sh = 6'd30;
                if (mac_done) begin
                    // negation commutes with symmetric rounding
                    corr_next = corr_reg + mac_res; state_next = ST_OUT;
                    issued_next = 1'b0;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    dbase_next = 32'(dbase_use);
                    ybase_next = 32'(ybase_use);
                    out_next = {32'(sat32(64'(yaw_reg) + ybase_use)),
                                32'(64'(pitch_reg) + 64'(ptrim_reg)),
                                32'(64'(roll_reg) + 64'(rtrim_reg)),
                                32'(sat32(dc + dbase_use)),
                                spd_reg};
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg != ST_IDLE && state_reg != ST_OUT && !issued_reg) begin
            mac_start = 1'b1; issued_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; issued_reg <= 1'b0; out_valid_reg <= 1'b0;
            sacc_reg <= '0; sdep_reg <= '0; spd_reg <= '0;
            dbase_reg <= '0; ybase_reg <= '0;
            fuse_reg <= FuseReset; smooth_reg <= SmoothReset;
            stept_reg <= StepTReset; rate_reg <= StepRReset;
            rtrim_reg <= '0; ptrim_reg <= '0;
            levf_reg <= LevFReset; levs_reg <= LevSReset;
        end else begin
            state_reg <= state_next; issued_reg <= issued_next;
            out_valid_reg <= out_valid_next;
            sacc_reg <= sacc_next; sdep_reg <= sdep_next; spd_reg <= spd_next;
            dbase_reg <= dbase_next; ybase_reg <= ybase_next;
            if (cfg_valid) begin
                case (reg_idx_t'(cfg_index))
                    REG_FUSE:       fuse_reg <= cfg_data[16:0];
                    REG_SMOOTH:     smooth_reg <= cfg_data[16:0];
                    REG_STEP_TIME:  stept_reg <= cfg_data[24:0];
                    REG_STEP_RATE:  rate_reg <= cfg_data[16:0];
                    REG_ROLL_TRIM:  rtrim_reg <= cfg_data[24:0];
                    REG_PITCH_TRIM: ptrim_reg <= cfg_data[24:0];
                    REG_LEVER_FWD:  levf_reg <= cfg_data;
                    REG_LEVER_SIDE: levs_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        if (s_tvalid && s_tready) begin
            acc_in_reg <= s_tdata[31:0]; dep_in_reg <= s_tdata[63:32];
            roll_reg <= s_tdata[88:64]; pitch_reg <= s_tdata[113:89];
            yaw_reg <= s_tdata[138:114]; arm_reg <= s_tuser;
        end
        tmp_reg <= tmp_next; va_reg <= va_next; corr_reg <= corr_next;
        old_dep_reg <= old_dep_next; out_reg <= out_next;
    end
endmodule

### rtl/vsdf_checker.sv
// port-level checks for the vertical speed and depth fusion block
module vsdf_checker import vsdf_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);
    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
    // an accepted item is not followed by another acceptance next cycle
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("input taken twice");
    // no result right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid) else $error("valid after reset");
    // a new result is loaded while the input side is busy with its item
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready)) else $error("result without item");
endmodule

bind vertical_speed_depth_fusion_top vsdf_checker u_vsdf_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### tb/sv/vertical_speed_depth_fusion_top_tb.sv
// testbench for the vertical speed and depth fusion block: random and directed samples
`timescale 1ns / 1ps

module vertical_speed_depth_fusion_top_tb;
    import vsdf_pkg::*;

    // predicts the fused results of each sample, packed as on m_tdata, and checks them
    class fusion_predictor;
        longint sine_q30 [SineEntries + 1];
        longint fuse_w, smooth_w, step_t, step_r, roll_trim, pitch_trim, lev_fwd, lev_side;
        longint acc_lp, depth_lp, speed, depth_base, yaw_base;
        logic [159:0] expected_results [$];
        int fails;

        function new();
            longint unsigned x, x2, t;
            longint s;
            for (int i = 0; i <= SineEntries; i++) begin
                x  = (longint'(i) * 64'd1686629713) / SineEntries;
                x2 = (x * x) >> 30;
                t  = x;
                s  = longint'(x);
                for (int k = 1; k <= 12; k++) begin
                    t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                    s = (k % 2 == 1) ? s - longint'(t) : s + longint'(t);
                end
                if (s < 0) s = 0;
                if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
                sine_q30[i] = s;
            end
            fuse_w = 64225; smooth_w = 6554; step_t = 16777; step_r = 1000;
            roll_trim = 0; pitch_trim = 0; lev_fwd = 8782; lev_side = -6881;
            acc_lp = 0; depth_lp = 0; speed = 0; depth_base = 0; yaw_base = 0;
            fails = 0;
        endfunction

        function longint clamp_s32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // rounds to nearest, ties away from zero
        function longint round_shift(longint v, int n);
            longint half;
            half = 64'sd1 <<< (n - 1);
            if (v >= 0) return (v + half) >>> n;
            return -((-v + half) >>> n);
        endfunction

        function longint smooth_q16(longint x, longint prev, longint w);
            return clamp_s32(round_shift(w * x + (65536 - w) * prev, 16));
        endfunction

        function longint sine_of(longint angle);
            longint unsigned mag, turn, ph, quad, idx;
            longint s;
            mag  = (angle < 0) ? -angle : angle;
            turn = 64'd360 << FracBits;
            ph   = ((mag * (4 * SineEntries) + (turn >> 1)) / turn) % (4 * SineEntries);
            quad = ph / SineEntries;
            idx  = ph % SineEntries;
            s = quad[0] ? sine_q30[SineEntries - idx] : sine_q30[idx];
            if (quad >= 2) s = -s;
            return (angle < 0) ? -s : s;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] d);
            case (idx)
                REG_FUSE:       fuse_w = d[16:0];
                REG_SMOOTH:     smooth_w = d[16:0];
                REG_STEP_TIME:  step_t = d[24:0];
                REG_STEP_RATE:  step_r = d[16:0];
                REG_ROLL_TRIM:  roll_trim = longint'(signed'(d[24:0]));
                REG_PITCH_TRIM: pitch_trim = longint'(signed'(d[24:0]));
                REG_LEVER_FWD:  lev_fwd = longint'(signed'(d));
                REG_LEVER_SIDE: lev_side = longint'(signed'(d));
                default: ;
            endcase
        endfunction

        function void note_sample(logic [143:0] d, logic arm);
            longint accel, depth, roll, pitch, yaw, alpha, beta, old_depth, vd, va, dc;
            logic [31:0] f [5];
            accel = longint'(signed'(d[31:0]));
            depth = longint'(signed'(d[63:32]));
            roll  = longint'(signed'(d[88:64]));
            pitch = longint'(signed'(d[113:89]));
            yaw   = longint'(signed'(d[138:114]));
            alpha = (fuse_w > 65536) ? 65536 : fuse_w;
            beta  = (smooth_w > 65536) ? 65536 : smooth_w;
            old_depth = depth_lp;
            acc_lp   = smooth_q16(accel + 642253, acc_lp, beta);
            depth_lp = smooth_q16(depth, depth_lp, beta);
            vd = clamp_s32((depth_lp - old_depth) * step_r);
            va = clamp_s32(speed + round_shift(acc_lp * step_t, 24));
            speed = clamp_s32(round_shift(alpha * va + (65536 - alpha) * vd, 16));
            dc = depth + round_shift(sine_of(pitch) * lev_fwd, 30)
                       - round_shift(sine_of(roll) * lev_side, 30);
            if (arm) begin
                depth_base = clamp_s32(-dc);
                yaw_base   = clamp_s32(-yaw);
            end
            f[0] = speed[31:0];
            f[1] = clamp_s32(dc + depth_base);
            f[2] = clamp_s32(roll + roll_trim);
            f[3] = clamp_s32(pitch + pitch_trim);
            f[4] = clamp_s32(yaw + yaw_base);
            expected_results.push_back({f[4], f[3], f[2], f[1], f[0]});
        endfunction

        function void check_result(logic [159:0] got);
            string names [5] = '{"vertical_speed", "depth_out", "roll_out", "pitch_out",
                                 "yaw_out"};
            logic [159:0] want;
            if (expected_results.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected result %h", got);
                return;
            end
            want = expected_results.pop_front();
            for (int i = 0; i < 5; i++) begin
                if (got[32*i +: 32] !== want[32*i +: 32]) begin
                    fails++;
                    if (fails <= 10)
                        $display("%s mismatch: expected %0d got %0d", names[i],
                                 $signed(want[32*i +: 32]), $signed(got[32*i +: 32]));
                end
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [159:0] m_tdata;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    fusion_predictor sb = new();
    int send_idle_pct = 0;
    int take_idle_pct = 0;

    vertical_speed_depth_fusion_top DUT (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // monitors sample pre-edge values
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) sb.set_register(reg_idx_t'(cfg_index), cfg_data);
        if (aresetn && s_tvalid && s_tready) sb.note_sample(s_tdata, s_tuser);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // receiver backpressure
    always @(posedge aclk)
        m_tready <= aresetn && ($urandom_range(99) >= take_idle_pct);

    task automatic write_reg(reg_idx_t idx, logic [31:0] d);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic send_sample(logic signed [31:0] accel, logic signed [31:0] depth,
                               logic [24:0] roll, logic [24:0] pitch, logic [24:0] yaw,
                               logic arm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {5'b0, yaw, pitch, roll, depth, accel};
        s_tuser  <= arm;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_sample();
        int accel, depth, r, p, y;
        accel = ($urandom_range(9) < 8) ? int'($urandom_range(2621440)) - 1310720
                                        : int'($urandom);
        depth = ($urandom_range(9) < 8) ? int'($urandom_range(6553600)) - 65536
                                        : int'($urandom);
        r = ($urandom_range(9) < 8) ? int'($urandom_range(23592960)) - 11796480 : $urandom;
        p = ($urandom_range(9) < 8) ? int'($urandom_range(23592960)) - 11796480 : $urandom;
        y = ($urandom_range(9) < 8) ? int'($urandom_range(23592960)) - 11796480 : $urandom;
        send_sample(accel, depth, r[24:0], p[24:0], y[24:0], $urandom_range(19) == 0);
    endtask

    // block is idle once every result is back and the pipeline has emptied
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] fw, sw, st, sr, rt, pt, lf, ls;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes of each field, wrapping angles, arm and saturated baselines
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 25'd5898240, 25'd5898240, 25'd11796480, 0);
        send_sample(32'sh80000000, 32'sh80000000, -25'sd5898240, -25'sd5898240,
                    -25'sd11796480, 0);
        send_sample(65536, 655360, 25'd11796480, -25'sd11796480, 25'd2949120, 0);
        send_sample(-65536, 327680, 25'h0FFFFFF, 25'h1000000, 25'h0FFFFFF, 0);
        send_sample(-32'sd642253, 1000, 25'h1000000, 25'h0FFFFFF, 25'h1000000, 0);
        send_sample(100000, 3276800, 25'd1966080, 25'd983040, 25'd1000, 1);
        send_sample(-200000, 3300000, 25'd1966080, 25'd983040, 25'd1000, 0);
        send_sample(32'sh80000000, 32'sh80000000, 25'd5898240, 25'd5898240,
                    25'h1000000, 1);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, -25'sd5898240, -25'sd5898240, 0, 1);
        send_sample(5, -5, 25'd90, -25'sd90, 25'd45, 0);
        send_sample(0, 0, 0, 0, 0, 1);
        for (int i = 0; i < 8; i++) send_random_sample();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            fw = $urandom_range(65536); sw = $urandom_range(65536);
            st = $urandom_range(1, 16777216); sr = $urandom_range(1, 100000);
            rt = int'($urandom_range(23592960)) - 11796480;
            pt = int'($urandom_range(23592960)) - 11796480;
            lf = $urandom; ls = $urandom;
            if (ph == 0) begin
                fw = 65536; sw = 65536; st = 16777216; sr = 100000;
                rt = 11796480; pt = 11796480; lf = 32'h7FFFFFFF; ls = 32'h7FFFFFFF;
            end else if (ph == 1) begin
                // zero weights, zero step values, lowest trims and levers
                fw = 0; sw = 0; st = 0; sr = 0;
                rt = -11796480; pt = -11796480; lf = 32'h80000000; ls = 32'h80000000;
            end else if (ph == 2) begin
                // weights above one act as one
                fw = 32'h1FFFF; sw = 32'h1FFFF;
            end
            write_reg(REG_FUSE, fw);
            write_reg(REG_SMOOTH, sw);
            write_reg(REG_STEP_TIME, st);
            write_reg(REG_STEP_RATE, sr);
            write_reg(REG_ROLL_TRIM, rt);
            write_reg(REG_PITCH_TRIM, pt);
            write_reg(REG_LEVER_FWD, lf);
            write_reg(REG_LEVER_SIDE, ls);
            cfg_valid <= 0;

            // idle pattern: sender-light first, then receiver-light, then none
            send_idle_pct = (ph < 2) ? 17 : (ph < 4) ? 55 : 0;
            take_idle_pct = (ph < 2) ? 55 : (ph < 4) ? 17 : 0;
            for (int i = 0; i < 240; i++) send_random_sample();
            drain();
        end

        if (sb.fails == 0 && sb.expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
